>>> rtl/ppfs_pkg.sv
package ppfs_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned GainW = 16;
  localparam logic [GainW-1:0] GainReset = 16'd256;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_HOLD   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_I,
    ST_RD_I,
    ST_SCAN_J,
    ST_RD_J,
    ST_DIFF,
    ST_SQRT,
    ST_DIV_INV,
    ST_F,
    ST_DIV_CX,
    ST_DIV_CY,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_e;

endpackage

>>> rtl/ppfs_divider.sv
module ppfs_divider
  import ppfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  // restoring divider, one quotient bit per cycle
  logic [63:0] num_q, num_d, quo_q, quo_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[63:0], num_q[63]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[62:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/pairwise_particle_force_step_top.sv
// sequence: a write, remove or hold transaction is taken in the idle state; a tick visits
//   each ordered pair of active slots, then writes back each slot, and result stalls
//   extend it; a pair waits three times on one shared 64-bit bit-serial divider and
//   once on the square root; a pair at distance 1.0 or less ends after the square root
// throughput: one transaction at a time; the next is accepted once the pass ends and its last result is taken
// reset: valid and held flags clear, force_gain returns to 1.0; positions
//   are undefined until written
module pairwise_particle_force_step_top
  import ppfs_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [GainW-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              mode_i,
  input  logic [4:0]              slot_i,
  input  logic signed [PosW-1:0]  pos_x_i,
  input  logic signed [PosW-1:0]  pos_y_i,
  input  logic                    held_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [4:0]              out_slot_o,
  output logic signed [PosW-1:0]  new_x_o,
  output logic signed [PosW-1:0]  new_y_o,
  output logic                    last_o
);

  localparam int unsigned IdxW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned CntW = $clog2(MAX_PARTICLES + 1);

  state_e state_q, state_d;

  logic [GainW-1:0] gain_q;
  logic [MAX_PARTICLES-1:0] valid_q, held_q;
  logic [MAX_PARTICLES-1:0] active;

  // position memory, x and y in one word
  logic [2*PosW-1:0] pos_mem [MAX_PARTICLES];
  logic [2*PosW-1:0] rd_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_wa, mem_ra;
  logic [2*PosW-1:0] mem_wd;

  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic signed [PosW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [PosW:0] dx_q, dx_d, dy_q, dy_d;
  logic        sh_q, sh_d;
  logic [63:0] sq_q, sq_d;
  logic [63:0] rad_q, rad_d, root_q, root_d, bit_q, bit_d;
  logic [63:0] dist_q, dist_d, inv_q, inv_d, f_q, f_d;
  logic [31:0] c_x_q, c_x_d, c_y_q, c_y_d;
  logic [5:0]  step_q, step_d;
  logic signed [PosW+8:0] sx_q, sx_d, sy_q, sy_d;
  logic [63:0] prod_x_q, prod_x_d, prod_y_q, prod_y_d;
  logic        found_q, found_d;
  logic [4:0]  oslot_q, oslot_d;
  logic signed [PosW-1:0] ox_q, ox_d, oy_q, oy_d;
  logic        olast_q, olast_d, ovalid_q, ovalid_d;

  logic        dv_start;
  logic [63:0] dv_num, dv_den, dv_quo;
  logic        dv_done;

  ppfs_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  assign active = valid_q & ~held_q;

  logic in_acc;
  assign in_ready_o = (state_q == ST_IDLE) && !ovalid_q;
  assign in_acc = in_valid_i && in_ready_o;

  // next active slot at or after a counter, skipping one given slot
  function automatic logic [CntW-1:0] next_act(input logic [MAX_PARTICLES-1:0] act,
                                               input logic [CntW-1:0] from,
                                               input logic [CntW-1:0] skip);
    logic [CntW-1:0] r;
    r = CntW'(MAX_PARTICLES);
    for (int k = MAX_PARTICLES - 1; k >= 0; k--) begin
      if (act[k] && CntW'(k) >= from && CntW'(k) != skip) r = CntW'(k);
    end
    return r;
  endfunction

  logic [CntW-1:0] nxt_i, nxt_j;
  assign nxt_i = next_act(active, i_q, CntW'(MAX_PARTICLES));
  assign nxt_j = next_act(active, j_q, i_q);

  logic [PosW:0] ax, ay;
  logic [63:0] trial_rem;
  logic [63:0] sq_add;
  logic signed [PosW+9:0] nx_w, ny_w;
  logic [63:0] mag_x, mag_y;

  always_comb begin
    state_d  = state_q;
    i_d = i_q; j_d = j_q;
    cx_d = cx_q; cy_d = cy_q;
    dx_d = dx_q; dy_d = dy_q;
    sh_d = sh_q; sq_d = sq_q;
    rad_d = rad_q; root_d = root_q; bit_d = bit_q;
    dist_d = dist_q; inv_d = inv_q; f_d = f_q;
    c_x_d = c_x_q; c_y_d = c_y_q;
    step_d = step_q;
    sx_d = sx_q; sy_d = sy_q;
    prod_x_d = prod_x_q; prod_y_d = prod_y_q;
    found_d = found_q;
    oslot_d = oslot_q; ox_d = ox_q; oy_d = oy_q; olast_d = olast_q;
    ovalid_d = ovalid_q;
    mem_we = 1'b0;
    mem_wa = i_q[IdxW-1:0];
    mem_wd = {cx_q, cy_q};
    mem_ra = i_q[IdxW-1:0];
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = dist_q;
    ax = dx_q[PosW] ? (PosW+1)'(0) - dx_q : dx_q;
    ay = dy_q[PosW] ? (PosW+1)'(0) - dy_q : dy_q;
    trial_rem = root_q + bit_q;
    sq_add = '0;
    mag_x = '0;
    mag_y = '0;
    nx_w = '0;
    ny_w = '0;

    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (mode_e'(mode_i))
            MODE_TICK: begin
              i_d = '0;
              found_d = 1'b0;
              state_d = ST_SCAN_I;
            end
            MODE_WRITE: begin
              mem_we = (32'(slot_i) < MAX_PARTICLES);
              mem_wa = IdxW'(slot_i);
              mem_wd = {pos_x_i, pos_y_i};
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_I: begin
        if (!ovalid_q || out_ready_i) begin
          if (nxt_i == CntW'(MAX_PARTICLES)) begin
            if (found_q) begin
              olast_d = 1'b1;
              ovalid_d = 1'b1;
            end
            state_d = ST_IDLE;
          end else begin
            if (found_q) ovalid_d = 1'b1;
            found_d = 1'b0;
            i_d = nxt_i;
            mem_ra = nxt_i[IdxW-1:0];
            state_d = ST_RD_I;
          end
        end
      end
      ST_RD_I: begin
        cx_d = rd_q[2*PosW-1:PosW];
        cy_d = rd_q[PosW-1:0];
        sx_d = '0; sy_d = '0;
        j_d = '0;
        state_d = ST_SCAN_J;
      end
      ST_SCAN_J: begin
        if (nxt_j == CntW'(MAX_PARTICLES)) begin
          state_d = ST_OUT;
        end else begin
          j_d = nxt_j;
          mem_ra = nxt_j[IdxW-1:0];
          state_d = ST_RD_J;
        end
      end
      ST_RD_J: begin
        dx_d = {rd_q[2*PosW-1], rd_q[2*PosW-1:PosW]} - {cx_q[PosW-1], cx_q};
        dy_d = {rd_q[PosW-1], rd_q[PosW-1:0]} - {cy_q[PosW-1], cy_q};
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        sh_d = ax[PosW] | ay[PosW] | ax[PosW-1] | ay[PosW-1];
        // squares summed via step: x square first, then y square added
        if (step_q == 6'd0) begin
          sq_add = sh_d ? 64'(ax[PosW:1]) * 64'(ax[PosW:1])
                        : 64'(ax[PosW-1:0]) * 64'(ax[PosW-1:0]);
          sq_d = sq_add;
          step_d = 6'd1;
        end else begin
          sq_add = sh_q ? 64'(ay[PosW:1]) * 64'(ay[PosW:1])
                        : 64'(ay[PosW-1:0]) * 64'(ay[PosW-1:0]);
          rad_d = sq_q + sq_add;
          root_d = '0;
          bit_d = 64'h4000_0000_0000_0000;
          step_d = 6'd0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (bit_q == '0) begin
          dist_d = sh_q ? {root_q[62:0], 1'b0} : root_q;
          if (dist_d <= 64'd65536) begin
            state_d = ST_SCAN_J;
            j_d = j_q + CntW'(1);
          end else begin
            dv_start = 1'b1;
            dv_num = 64'h0001_0000_0000_0000;
            dv_den = dist_d;
            state_d = ST_DIV_INV;
          end
        end else begin
          if (rad_q >= trial_rem) begin
            rad_d = rad_q - trial_rem;
            root_d = (root_q >> 1) + bit_q;
          end else begin
            root_d = root_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
      end
      ST_DIV_INV: begin
        if (dv_done) begin
          inv_d = dv_quo;
          prod_x_d = 64'(dv_quo[31:0]) * 64'(dv_quo[31:0]);
          state_d = ST_F;
        end
      end
      ST_F: begin
        // inv below 2^32 since dist > 2^16
        f_d = inv_q - {32'd0, prod_x_q[63:32]};
        dv_start = 1'b1;
        dv_num = 64'(ax) << 31;
        state_d = ST_DIV_CX;
      end
      ST_DIV_CX: begin
        if (dv_done) begin
          c_x_d = (dv_quo > 64'h8000_0000) ? 32'h8000_0000 : dv_quo[31:0];
          dv_start = 1'b1;
          dv_num = 64'(ay) << 31;
          state_d = ST_DIV_CY;
        end
      end
      ST_DIV_CY: begin
        if (dv_done) begin
          c_y_d = (dv_quo > 64'h8000_0000) ? 32'h8000_0000 : dv_quo[31:0];
          prod_x_d = 64'(f_q[31:0]) * 64'(c_x_q);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_y_d = 64'(f_q[31:0]) * 64'(c_y_q);
        prod_x_d = 64'(prod_x_q[63:32]) * 64'(gain_q);
        state_d = ST_ACC;
        step_d = 6'd0;
      end
      ST_ACC: begin
        if (step_q == 6'd0) begin
          prod_y_d = 64'(prod_y_q[63:32]) * 64'(gain_q);
          step_d = 6'd1;
        end else begin
          mag_x = prod_x_q >> 23;
          mag_y = prod_y_q >> 23;
          sx_d = dx_q[PosW] ? sx_q - (PosW+9)'(mag_x) : sx_q + (PosW+9)'(mag_x);
          sy_d = dy_q[PosW] ? sy_q - (PosW+9)'(mag_y) : sy_q + (PosW+9)'(mag_y);
          step_d = 6'd0;
          j_d = j_q + CntW'(1);
          state_d = ST_SCAN_J;
        end
      end
      ST_OUT: begin
        // output register is only reloaded once the previous transaction leaves
        if (!ovalid_q || out_ready_i) begin
          nx_w = (PosW+10)'(cx_q) + (PosW+10)'(sx_q);
          ny_w = (PosW+10)'(cy_q) + (PosW+10)'(sy_q);
          if (nx_w > (PosW+10)'(32'sh7FFF_FFFF)) ox_d = 32'sh7FFF_FFFF;
          else if (nx_w < -(PosW+10)'(33'sh0_8000_0000)) ox_d = 32'sh8000_0000;
          else ox_d = nx_w[PosW-1:0];
          if (ny_w > (PosW+10)'(32'sh7FFF_FFFF)) oy_d = 32'sh7FFF_FFFF;
          else if (ny_w < -(PosW+10)'(33'sh0_8000_0000)) oy_d = 32'sh8000_0000;
          else oy_d = ny_w[PosW-1:0];
          mem_we = 1'b1;
          mem_wa = i_q[IdxW-1:0];
          mem_wd = {ox_d, oy_d};
          oslot_d = 5'(i_q);
          olast_d = 1'b0;
          found_d = 1'b1;
          i_d = i_q + CntW'(1);
          state_d = ST_SCAN_I;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      gain_q   <= GainReset;
      valid_q  <= '0;
      held_q   <= '0;
      ovalid_q <= 1'b0;
      found_q  <= 1'b0;
      step_q   <= '0;
      i_q      <= '0;
      j_q      <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      found_q  <= found_d;
      step_q   <= step_d;
      i_q      <= i_d;
      j_q      <= j_d;
      if (cfg_we_i) gain_q <= cfg_wdata_i;
      if (in_acc && mode_i != MODE_TICK && 32'(slot_i) < MAX_PARTICLES) begin
        case (mode_e'(mode_i))
          MODE_WRITE: valid_q[IdxW'(slot_i)] <= 1'b1;
          MODE_REMOVE: begin
            valid_q[IdxW'(slot_i)] <= 1'b0;
            held_q[IdxW'(slot_i)]  <= 1'b0;
          end
          default: held_q[IdxW'(slot_i)] <= held_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d; cy_q <= cy_d;
    dx_q <= dx_d; dy_q <= dy_d;
    sh_q <= sh_d; sq_q <= sq_d;
    rad_q <= rad_d; root_q <= root_d; bit_q <= bit_d;
    dist_q <= dist_d; inv_q <= inv_d; f_q <= f_d;
    c_x_q <= c_x_d; c_y_q <= c_y_d;
    sx_q <= sx_d; sy_q <= sy_d;
    prod_x_q <= prod_x_d; prod_y_q <= prod_y_d;
    oslot_q <= oslot_d; ox_q <= ox_d; oy_q <= oy_d; olast_q <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) pos_mem[mem_wa] <= mem_wd;
    rd_q <= pos_mem[mem_ra];
  end

  assign out_valid_o = ovalid_q;
  assign out_slot_o  = oslot_q;
  assign new_x_o     = ox_q;
  assign new_y_o     = oy_q;
  assign last_o      = olast_q;

endmodule

>>> rtl/ppfs_checker.sv
module ppfs_checker
  import ppfs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [4:0] out_slot_o,
  input logic       last_o
);

  logic [4:0] prev_slot_q;
  logic       in_pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_slot_q <= '0;
      in_pass_q   <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      prev_slot_q <= out_slot_o;
      in_pass_q   <= !last_o;
    end
  end

  // results only while a tick is in flight: input side is closed then
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input open while result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_slot_o) && $stable(last_o))
    else $error("result changed while stalled");

  // slots in a pass ascend
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && in_pass_q |-> out_slot_o > prev_slot_q)
    else $error("order");

endmodule

bind pairwise_particle_force_step_top ppfs_checker u_ppfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_slot_o  (out_slot_o),
  .last_o      (last_o)
);

>>> test/pairwise_particle_force_step_checker.sv
`timescale 1ns / 100ps

module pairwise_particle_force_step_checker
  import ppfs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [GainW-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [1:0]             mode_i,
  input  logic [4:0]             slot_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic                   held_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [4:0]             out_slot_i,
  input  logic signed [PosW-1:0] new_x_i,
  input  logic signed [PosW-1:0] new_y_i,
  input  logic                   last_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     moves_seen_o
);

  typedef struct packed {
    logic [4:0]             slot;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic                   last;
  } move_t;

  move_t                   moves_q[$];
  logic [GainW-1:0]        gain;
  logic signed [PosW-1:0]  px[32];
  logic signed [PosW-1:0]  py[32];
  logic [31:0]             occupied;
  logic [31:0]             pinned;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint axis_push(longint da, longint unsigned span,
                                       longint unsigned f);
    longint unsigned a;
    longint unsigned c;
    longint unsigned mag;
    a = (da < 0) ? longint'(-da) : longint'(da);
    c = (a << 31) / span;
    if (c > (64'd1 << 31)) c = 64'd1 << 31;
    mag = (((f * c) >> 32) * longint'(gain)) >> 23;
    return (da < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [PosW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // one pass of the force step, updating positions in place
  task automatic predict_tick();
    longint cx, cy, sx, sy, dx, dy;
    longint unsigned ax, ay, span, inv, f;
    int sh;
    int n;
    move_t m;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (!occupied[i] || pinned[i]) continue;
      cx = px[i];
      cy = py[i];
      sx = 0;
      sy = 0;
      for (int j = 0; j < 32; j++) begin
        if (j == i || !occupied[j] || pinned[j]) continue;
        dx = longint'(px[j]) - cx;
        dy = longint'(py[j]) - cy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sh = (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) ? 1 : 0;
        ax = ax >> sh;
        ay = ay >> sh;
        span = int_sqrt(ax * ax + ay * ay) << sh;
        if (span <= 65536) continue;
        inv = (64'd1 << 48) / span;
        f = inv - ((inv * inv) >> 32);
        sx += axis_push(dx, span, f);
        sy += axis_push(dy, span, f);
      end
      px[i] = clamp32(cx + sx);
      py[i] = clamp32(cy + sy);
      m.slot = i[4:0];
      m.x = px[i];
      m.y = py[i];
      m.last = 1'b0;
      moves_q.push_back(m);
      n++;
    end
    if (n > 0) moves_q[moves_q.size()-1].last = 1'b1;
  endtask

  assign pending_o = moves_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    move_t exp_m;
    int    errs;
    errs = 0;
    if (!rst_ni) begin
      gain <= GainReset;
      occupied = '0;
      pinned = '0;
      fail_count_o <= 0;
      moves_seen_o <= 0;
    end else begin
      if (cfg_we_i) gain <= cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        moves_seen_o <= moves_seen_o + 1;
        if (moves_q.size() == 0) begin
          $error("unexpected result transaction slot %0d", out_slot_i);
          errs++;
        end else begin
          exp_m = moves_q.pop_front();
          if (out_slot_i !== exp_m.slot) begin
            $error("out_slot expected %0d actual %0d", exp_m.slot, out_slot_i);
            errs++;
          end
          if (new_x_i !== exp_m.x) begin
            $error("new_x expected %0h actual %0h", exp_m.x, new_x_i);
            errs++;
          end
          if (new_y_i !== exp_m.y) begin
            $error("new_y expected %0h actual %0h", exp_m.y, new_y_i);
            errs++;
          end
          if (last_i !== exp_m.last) begin
            $error("last expected %0d actual %0d", exp_m.last, last_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (in_valid_i && in_ready_i) begin
        case (mode_i)
          MODE_TICK: predict_tick();
          MODE_WRITE: begin
            px[slot_i] = pos_x_i;
            py[slot_i] = pos_y_i;
            occupied[slot_i] = 1'b1;
          end
          MODE_REMOVE: begin
            occupied[slot_i] = 1'b0;
            pinned[slot_i] = 1'b0;
          end
          default: pinned[slot_i] = held_i;
        endcase
      end
    end
  end

endmodule

>>> test/pairwise_particle_force_step_top_test.sv
`timescale 1ns / 100ps

module pairwise_particle_force_step_top_test;
  import ppfs_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [GainW-1:0]       cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             mode;
  logic [4:0]             slot;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic                   held;
  logic                   out_valid;
  logic                   out_ready;
  logic [4:0]             out_slot;
  logic signed [PosW-1:0] new_x;
  logic signed [PosW-1:0] new_y;
  logic                   last;
  int                     fail_count;
  int                     pending;
  int                     moves_seen;
  int                     events_sent;
  int                     ticks_sent;
  int                     burst_left;
  int                     active_cap;
  longint                 cycles;
  logic [31:0]            mirror_valid;
  logic [31:0]            mirror_held;

  pairwise_particle_force_step_top #(.MAX_PARTICLES(32)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .slot_i      (slot),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .held_i      (held),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_slot_o  (out_slot),
    .new_x_o     (new_x),
    .new_y_o     (new_y),
    .last_o      (last)
  );

  pairwise_particle_force_step_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .mode_i       (mode),
    .slot_i       (slot),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .held_i       (held),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_slot_i   (out_slot),
    .new_x_i      (new_x),
    .new_y_i      (new_y),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .moves_seen_o (moves_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver stall pattern steps through four phases driven by the cycle counter
  always @(posedge clk_i or negedge rst_ni) begin
    int phase;
    phase = int'((cycles / 64) % 4);
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      case (phase)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((cycles % 7) < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400_000_000) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(logic [1:0] m, logic [4:0] s, logic [31:0] x, logic [31:0] y,
                      logic h);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 30 : int'($urandom_range(1, 6));
    end
    in_valid <= 1'b1;
    mode <= m;
    slot <= s;
    pos_x <= x;
    pos_y <= y;
    held <= h;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    burst_left--;
    events_sent++;
    case (m)
      MODE_TICK: ticks_sent++;
      MODE_WRITE: mirror_valid[s] = 1'b1;
      MODE_REMOVE: begin
        mirror_valid[s] = 1'b0;
        mirror_held[s] = 1'b0;
      end
      default: mirror_held[s] = h;
    endcase
  endtask

  task automatic write_gain(logic [GainW-1:0] g);
    in_valid <= 1'b0;
    // wait for the clock so the last accepted tick is already predicted
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // a tick with nothing to move may still be scanning
    repeat (400) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic int moving_count();
    return $countones(mirror_valid & ~mirror_held);
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
  endfunction

  task automatic random_event();
    int r;
    logic [4:0] s;
    r = int'($urandom_range(0, 99));
    s = 5'($urandom_range(0, 31));
    if (r < 22) begin
      send(MODE_TICK, 5'($urandom), $urandom, $urandom, 1'($urandom));
    end else if (r < 70) begin
      // keep passes short: only move slots already present once at the cap
      if (!mirror_valid[s] && moving_count() >= active_cap && mirror_valid != 0) begin
        do s = 5'($urandom_range(0, 31)); while (!mirror_valid[s]);
      end
      send(MODE_WRITE, s, rand_coord(), rand_coord(), 1'($urandom));
    end else if (r < 85) begin
      send(MODE_REMOVE, s, $urandom, $urandom, 1'($urandom));
    end else begin
      if (moving_count() >= active_cap && !mirror_held[s]) send(MODE_HOLD, s, 0, 0, 1'b1);
      else send(MODE_HOLD, s, $urandom, $urandom, 1'($urandom));
    end
  endtask

  initial begin
    cycles = 0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    mode = MODE_TICK;
    slot = '0;
    pos_x = '0;
    pos_y = '0;
    held = 1'b0;
    events_sent = 0;
    ticks_sent = 0;
    burst_left = 0;
    active_cap = 5;
    mirror_valid = '0;
    mirror_held = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tick, hold before write, extremes, near pair, removals
    send(MODE_TICK, 5'd0, 0, 0, 1'b0);
    send(MODE_HOLD, 5'd5, 0, 0, 1'b1);
    send(MODE_WRITE, 5'd5, 32'h0010_0000, 32'h0010_0000, 1'b0);
    send(MODE_WRITE, 5'd0, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send(MODE_WRITE, 5'd31, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send(MODE_WRITE, 5'd1, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send(MODE_WRITE, 5'd2, 32'h0000_8000, 32'h0000_0000, 1'b0);
    send(MODE_TICK, 5'd31, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send(MODE_REMOVE, 5'd4, 0, 0, 1'b0);
    send(MODE_HOLD, 5'd5, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send(MODE_TICK, 5'd0, 0, 0, 1'b0);
    send(MODE_REMOVE, 5'd31, 0, 0, 1'b0);
    send(MODE_REMOVE, 5'd1, 0, 0, 1'b0);
    send(MODE_WRITE, 5'd3, 32'h0003_0000, 32'hfffc_0000, 1'b0);
    send(MODE_HOLD, 5'd2, 0, 0, 1'b1);
    send(MODE_TICK, 5'd0, 0, 0, 1'b0);
    write_gain(16'hffff);
    send(MODE_TICK, 5'd0, 0, 0, 1'b0);
    write_gain(16'h0000);
    send(MODE_TICK, 5'd0, 0, 0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_gain(GainReset);
        1: write_gain(16'hffff);
        2: write_gain(16'($urandom));
        default: write_gain(16'h0001);
      endcase
      active_cap = (ph == 2) ? 9 : 5;
      repeat (67) random_event();
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("sent %0d events (%0d ticks), checked %0d position updates over %0d cycles",
             events_sent, ticks_sent, moves_seen, cycles);
    $display("gain settings 0, 1, 256, 65535 and a random one were used");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ppfs_pkg.sv
rtl/ppfs_divider.sv
rtl/pairwise_particle_force_step_top.sv
rtl/ppfs_checker.sv
test/pairwise_particle_force_step_checker.sv
test/pairwise_particle_force_step_top_test.sv
